// ----- rtl/gyro_angle_kalman_filter_top_defines.svh -----
// Assertion macros shared by the gyro angle Kalman filter RTL.
// No dependencies; pulled in by the modules that carry assertions.
`ifndef GYRO_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH
`define GYRO_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define GAKF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define GAKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gakf_pkg.sv -----
// Shared types, codes and constants of the gyro angle Kalman filter.
// No dependencies; imported by every module of the block.
package gakf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int DT_W            = 24;
    localparam int NOISE_W         = 31;
    localparam int FRAC_CV         = 24;
    localparam int DIGIT_W         = 16;
    localparam int CFG_IDX_W       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd3;

    // reset values
    localparam logic [NOISE_W-1:0]       ANGLE_NOISE_RST = 31'd16777;
    localparam logic [NOISE_W-1:0]       BIAS_NOISE_RST  = 31'd50332;
    localparam logic [NOISE_W-1:0]       MEAS_NOISE_RST  = 31'd503316;
    localparam logic signed [DATA_W-1:0] START_ANGLE_RST = 32'sd11796480;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUTPUT
    } t_state;

    // filter sequence, executed in order
    typedef enum logic [4:0] {
        SP_RATE,
        SP_M_ANGLE,
        SP_M_D11,
        SP_INNER,
        SP_M_P00,
        SP_M_P11,
        SP_S,
        SP_D_K0,
        SP_D_K1,
        SP_Y,
        SP_M_ANG2,
        SP_M_BIAS,
        SP_M_C10,
        SP_M_C11,
        SP_M_C00,
        SP_M_C01,
        SP_DONE
    } t_step;

    typedef enum logic [1:0] {
        KIND_ALU,
        KIND_MUL,
        KIND_DIV,
        KIND_END
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  start;
        logic  exec;
        logic  out_load;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic s_pos;
    } t_status;

    function automatic t_kind step_kind(input t_step s);
        t_kind k;
        unique case (s) inside
            SP_RATE, SP_INNER, SP_S, SP_Y: k = KIND_ALU;
            SP_D_K0, SP_D_K1:              k = KIND_DIV;
            SP_DONE:                       k = KIND_END;
            default:                       k = KIND_MUL;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/gakf_mul.sv -----
// Signed fixed-point multiplier, 16-bit digit per cycle, result >> 24.
// Depends on gakf_pkg.
module gakf_mul import gakf_pkg::*; #(
    parameter int OW = DATA_W,
    parameter int XW = DATA_W + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [OW:0]   i_a,
    input  logic signed [OW:0]   i_b,
    output logic                 o_done,
    output logic signed [XW-1:0] o_res
);

    localparam int ND  = (OW + DIGIT_W - 1) / DIGIT_W;
    localparam int BW  = ND * DIGIT_W;
    localparam int AW  = BW + OW;
    localparam int SHW = AW - FRAC_CV;
    localparam int CW  = $clog2(ND + 1);

    logic [OW-1:0]         r_a;
    logic [BW-1:0]         r_b;
    logic [AW-1:0]         r_acc;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic signed [XW-1:0]  r_res;

    logic [OW-1:0]         w_mag_a;
    logic [OW-1:0]         w_mag_b;
    logic [OW+DIGIT_W-1:0] w_pp;
    logic [SHW-1:0]        w_sh;
    logic                  w_big;
    logic [XW-2:0]         w_mag;
    logic signed [XW-1:0]  w_res;

    assign w_mag_a = i_a[OW] ? OW'(-i_a) : OW'(i_a);
    assign w_mag_b = i_b[OW] ? OW'(-i_b) : OW'(i_b);
    assign w_pp    = r_a * r_b[BW-1 -: DIGIT_W];

    // drop fraction bits, cap far above any saturation point
    assign w_sh  = r_acc[AW-1:FRAC_CV];
    assign w_big = |w_sh[SHW-1:XW-2];
    assign w_mag = w_big ? {1'b1, {(XW-2){1'b0}}} : {1'b0, w_sh[XW-3:0]};
    assign w_res = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= w_mag_a;
            r_b   <= BW'(w_mag_b);
            r_acc <= '0;
            r_neg <= i_a[OW] ^ i_b[OW];
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_acc <= (r_acc << DIGIT_W) + AW'(w_pp);
                r_b   <= r_b << DIGIT_W;
            end else begin
                r_res <= w_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/gakf_div.sv -----
// Restoring divider for the gains: (|n| << 24) / d, signed, saturated.
// Depends on gakf_pkg.
module gakf_div import gakf_pkg::*; #(
    parameter int W  = VALUE_WIDTH_DEF,
    parameter int OW = DATA_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic [OW-1:0]       i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_res
);

    localparam int NB = W + FRAC_CV;
    localparam int CW = $clog2(NB + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic [NB-1:0]       r_dvd;
    logic [NB-1:0]       r_q;
    logic [OW-1:0]       r_rem;
    logic [OW-1:0]       r_den;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic signed [W-1:0] r_res;

    logic [W-1:0]        w_mag;
    logic [OW:0]         w_trial;
    logic [OW:0]         w_diff;
    logic                w_ge;
    logic                w_big;
    logic signed [W-1:0] w_res;

    assign w_mag   = i_num[W-1] ? W'(-i_num) : W'(i_num);
    assign w_trial = {r_rem, r_dvd[NB-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_big   = |r_q[NB-1:W-1];

    always_comb begin
        if (w_big) begin
            w_res = r_neg ? VMIN : VMAX;
        end else if (r_neg) begin
            w_res = -$signed(r_q[W-1:0]);
        end else begin
            w_res = $signed(r_q[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {w_mag, {FRAC_CV{1'b0}}};
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[W-1];
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= w_ge ? w_diff[OW-1:0] : w_trial[OW-1:0];
                r_q   <= {r_q[NB-2:0], w_ge};
                r_dvd <= r_dvd << 1;
            end else begin
                r_res <= w_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/gakf_dp.sv -----
// Filter datapath: state, config registers, operand select, write-back.
// Depends on gakf_pkg, gakf_mul and gakf_div.
module gakf_dp import gakf_pkg::*; #(
    parameter int W = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DATA_W-1:0]      i_cfg_data,
    input  logic signed [DATA_W-1:0] i_gyro_rate,
    input  logic signed [DATA_W-1:0] i_measured_angle,
    input  logic [DT_W-1:0]        i_time_step,
    output logic signed [DATA_W-1:0] o_angle_estimate,
    output logic signed [DATA_W-1:0] o_corrected_rate
);

    localparam int OW  = (W > DATA_W) ? W : DATA_W;
    localparam int MOW = OW + 1;
    localparam int XW  = OW + 4;
    localparam int EW  = XW + 2;
    localparam logic signed [EW-1:0] VMAX    = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] VMIN    = ~VMAX;
    localparam logic signed [EW-1:0] OMAX    = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] OMIN    = ~OMAX;
    localparam logic signed [EW-1:0] START_E = EW'(START_ANGLE_RST);

    function automatic logic signed [W-1:0] sat_v(input logic signed [EW-1:0] v);
        if (v > VMAX) begin
            return VMAX[W-1:0];
        end else if (v < VMIN) begin
            return VMIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [EW-1:0] ext(input logic signed [W-1:0] v);
        return EW'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_o(input logic signed [W-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > OMAX) begin
            return OMAX[DATA_W-1:0];
        end else if (e < OMIN) begin
            return OMIN[DATA_W-1:0];
        end
        return e[DATA_W-1:0];
    endfunction

    // filter state
    logic signed [W-1:0]      r_angle, r_bias, r_last_rate;
    logic signed [W-1:0]      r_p00, r_p01, r_p10, r_p11;
    // per-sample temporaries
    logic signed [W-1:0]      r_inner, r_k0, r_k1, r_y;
    logic signed [XW-1:0]     r_d11;
    logic [OW-1:0]            r_s;
    logic                     r_s_pos;
    logic signed [DATA_W-1:0] r_rate, r_meas;
    logic [DT_W-1:0]          r_dt;
    logic [NOISE_W-1:0]       r_apn, r_bpn, r_mn;
    logic signed [DATA_W-1:0] r_out_angle, r_out_rate;

    logic signed [MOW-1:0]    w_ma, w_mb;
    logic                     w_mul_done, w_div_done;
    logic signed [XW-1:0]     w_mres;
    logic signed [W-1:0]      w_dres;
    logic signed [W-1:0]      w_num;
    logic signed [EW-1:0]     w_m, w_d11, w_s;
    logic signed [MOW-1:0]    w_dt_op;

    assign w_m     = EW'(w_mres);
    assign w_d11   = EW'(r_d11);
    assign w_s     = ext(r_p00) + $signed(EW'(r_mn));
    assign w_dt_op = $signed(MOW'(r_dt));
    assign w_num   = (i_cmd.step == SP_D_K1) ? r_p10 : r_p00;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.step)
            SP_M_ANGLE: begin w_ma = w_dt_op;              w_mb = MOW'(r_last_rate); end
            SP_M_D11:   begin w_ma = w_dt_op;              w_mb = MOW'(r_p11);       end
            SP_M_P00:   begin w_ma = w_dt_op;              w_mb = MOW'(r_inner);     end
            SP_M_P11:   begin w_ma = $signed(MOW'(r_bpn)); w_mb = w_dt_op;           end
            SP_M_ANG2:  begin w_ma = MOW'(r_k0);           w_mb = MOW'(r_y);         end
            SP_M_BIAS:  begin w_ma = MOW'(r_k1);           w_mb = MOW'(r_y);         end
            SP_M_C10:   begin w_ma = MOW'(r_k1);           w_mb = MOW'(r_p00);       end
            SP_M_C11:   begin w_ma = MOW'(r_k1);           w_mb = MOW'(r_p01);       end
            SP_M_C00:   begin w_ma = MOW'(r_k0);           w_mb = MOW'(r_p00);       end
            SP_M_C01:   begin w_ma = MOW'(r_k0);           w_mb = MOW'(r_p01);       end
            default:    begin w_ma = '0;                   w_mb = '0;                end
        endcase
    end

    gakf_mul #(.OW(OW), .XW(XW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && (step_kind(i_cmd.step) == KIND_MUL)),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_res   (w_mres)
    );

    gakf_div #(.W(W), .OW(OW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && (step_kind(i_cmd.step) == KIND_DIV)),
        .i_num   (w_num),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_res   (w_dres)
    );

    // filter state, config and write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn       <= ANGLE_NOISE_RST;
            r_bpn       <= BIAS_NOISE_RST;
            r_mn        <= MEAS_NOISE_RST;
            r_angle     <= sat_v(START_E);
            r_bias      <= '0;
            r_last_rate <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
            r_s_pos     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ANGLE_NOISE: r_apn   <= i_cfg_data[NOISE_W-1:0];
                    CFG_BIAS_NOISE:  r_bpn   <= i_cfg_data[NOISE_W-1:0];
                    CFG_MEAS_NOISE:  r_mn    <= i_cfg_data[NOISE_W-1:0];
                    CFG_START_ANGLE: r_angle <= sat_v(EW'($signed(i_cfg_data)));
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                case (i_cmd.step)
                    SP_RATE:    r_last_rate <= sat_v(EW'(r_rate) - ext(r_bias));
                    SP_M_ANGLE: r_angle     <= sat_v(ext(r_angle) + w_m);
                    SP_M_D11:   r_d11       <= w_mres;
                    SP_INNER:   r_inner     <= sat_v(w_d11 - ext(r_p01) - ext(r_p10)
                                                     + $signed(EW'(r_apn)));
                    SP_M_P00: begin
                        r_p00 <= sat_v(ext(r_p00) + w_m);
                        r_p01 <= sat_v(ext(r_p01) - w_d11);
                        r_p10 <= sat_v(ext(r_p10) - w_d11);
                    end
                    SP_M_P11:   r_p11   <= sat_v(ext(r_p11) + w_m);
                    SP_S: begin
                        r_s     <= w_s[OW-1:0];
                        // positive: sign clear and not zero
                        r_s_pos <= !w_s[EW-1] && (w_s != '0);
                        r_k0    <= '0;
                        r_k1    <= '0;
                    end
                    SP_D_K0:    r_k0    <= w_dres;
                    SP_D_K1:    r_k1    <= w_dres;
                    SP_Y:       r_y     <= sat_v(EW'(r_meas) - ext(r_angle));
                    SP_M_ANG2:  r_angle <= sat_v(ext(r_angle) + w_m);
                    SP_M_BIAS:  r_bias  <= sat_v(ext(r_bias) + w_m);
                    SP_M_C10:   r_p10   <= sat_v(ext(r_p10) - w_m);
                    SP_M_C11:   r_p11   <= sat_v(ext(r_p11) - w_m);
                    SP_M_C00:   r_p00   <= sat_v(ext(r_p00) - w_m);
                    SP_M_C01:   r_p01   <= sat_v(ext(r_p01) - w_m);
                    default: ;
                endcase
            end
        end
    end

    // sample capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rate <= i_gyro_rate;
            r_meas <= i_measured_angle;
            r_dt   <= i_time_step;
        end
        if (i_cmd.out_load) begin
            r_out_angle <= sat_o(r_angle);
            r_out_rate  <= sat_o(r_last_rate);
        end
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.div_done = w_div_done;
    assign o_status.s_pos    = r_s_pos;
    assign o_angle_estimate  = r_out_angle;
    assign o_corrected_rate  = r_out_rate;

endmodule

// ----- rtl/gakf_ctrl.sv -----
// Sequencer of the filter steps and owner of the handshakes.
// Depends on gakf_pkg and gyro_angle_kalman_filter_top_defines.svh.
`include "gyro_angle_kalman_filter_top_defines.svh"

module gakf_ctrl import gakf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;
    t_kind  w_kind;
    t_step  w_step_inc;
    logic   w_out_free;
    logic   w_done_now;

    assign w_kind     = step_kind(r_step);
    assign w_step_inc = t_step'(5'(r_step + 5'd1));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_done_now = (w_kind == KIND_MUL) ? i_status.mul_done : i_status.div_done;

    // next state
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = (r_out_valid && !i_stall) ? 1'b0 : r_out_valid;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_ISSUE;
                    n_step  = SP_RATE;
                end
            end
            ST_ISSUE: begin
                unique case (w_kind)
                    KIND_ALU: n_step = w_step_inc;
                    KIND_MUL: n_state = ST_WAIT;
                    KIND_DIV: begin
                        if (i_status.s_pos) begin
                            n_state = ST_WAIT;
                        end else begin
                            n_step = SP_Y;
                        end
                    end
                    KIND_END: n_state = ST_OUTPUT;
                    default: ;
                endcase
            end
            ST_WAIT: begin
                if (w_done_now) begin
                    n_state = ST_ISSUE;
                    n_step  = w_step_inc;
                end
            end
            ST_OUTPUT: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = r_step;
        o_stall        = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_ISSUE: begin
                o_cmd.exec  = (w_kind == KIND_ALU);
                o_cmd.start = (w_kind == KIND_MUL) ||
                              ((w_kind == KIND_DIV) && i_status.s_pos);
            end
            ST_WAIT:   o_cmd.exec     = w_done_now;
            ST_OUTPUT: o_cmd.out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SP_RATE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    `GAKF_ASSERT_SAME(a_load_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || !i_stall, "result register overwritten")
    `GAKF_ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, i_valid && !o_stall, (r_state == ST_ISSUE) && (r_step == SP_RATE), "sample accepted without starting sequence")
    `GAKF_ASSERT_SAME(a_mul_wait, i_clk, i_rst_n, i_status.mul_done, (r_state == ST_WAIT) && (w_kind == KIND_MUL), "multiplier finished outside a wait")
    `GAKF_ASSERT_SAME(a_div_wait, i_clk, i_rst_n, i_status.div_done, (r_state == ST_WAIT) && (w_kind == KIND_DIV), "divider finished outside a wait")

endmodule

// ----- rtl/gyro_angle_kalman_filter_top.sv -----
// Top level of the gyro angle Kalman filter (angle and gyro bias states).
// Depends on gakf_pkg, gakf_ctrl and gakf_dp.
//
// Usage:
//  - Sample channel: i_valid with o_stall. A transaction carries gyro rate
//    (Q16.16), measured angle (Q16.16) and time step (Q0.24).
//  - Result channel: o_valid with i_stall. Each sample yields exactly one
//    transaction: filtered angle and bias-corrected rate, both Q16.16 saturated.
//  - Config channel: i_cfg_valid / o_cfg_ready (always ready), register index
//    and 32-bit data; 0 angle noise, 1 bias noise, 2 measure noise, 3 start
//    angle (also reloads the angle estimate). Other indexes are ignored.
//    Write only while the filter is idle.
//  - One shared 16-bit-digit multiplier (ten products per sample) and one
//    bit-serial restoring divider (two gains per sample) do the arithmetic.
//    The gain divisions are skipped when the innovation variance is not
//    positive.
//  - One sample in flight: the next sample is taken only after the last
//    one has reached the output register.
//  - Reset (synchronous, active low): registers return to defaults, the
//    angle loads the start angle, bias and covariance clear, no result pends.
//  - A stalled result sits in the output register; the next sample is still
//    taken and computed, and waits only for that register to drain.
module gyro_angle_kalman_filter_top import gakf_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_gyro_rate,
    input  logic signed [DATA_W-1:0] i_measured_angle,
    input  logic [DT_W-1:0]          i_time_step,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_angle_estimate,
    output logic signed [DATA_W-1:0] o_corrected_rate,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // config writes are plain register loads, so the channel is always ready
    assign o_cfg_ready = 1'b1;

    gakf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    gakf_dp #(.W(VALUE_WIDTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_gyro_rate      (i_gyro_rate),
        .i_measured_angle (i_measured_angle),
        .i_time_step      (i_time_step),
        .o_angle_estimate (o_angle_estimate),
        .o_corrected_rate (o_corrected_rate)
    );

endmodule

// ----- tb/gyro_angle_kalman_filter_top_tb.sv -----
// Self-checking testbench for gyro_angle_kalman_filter_top: angle/bias filter.
// Depends on gakf_pkg and the RTL; a built-in filter predictor checks every result.
`timescale 1ns / 100ps

module gyro_angle_kalman_filter_top_tb;
    import gakf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;  // no register behind it
    localparam int  CYCLE_LIMIT = 5_000_000;
    localparam int  DRAIN_CYCLES = 200;
    localparam longint Q_CAP = 64'sd1 << 62;

    typedef struct {
        logic signed [DATA_W-1:0] rate;
        logic signed [DATA_W-1:0] meas;
        logic [DT_W-1:0]          dt;
    } t_sample;

    typedef struct {
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] rate;
    } t_estimate;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_gyro_rate;
    logic signed [DATA_W-1:0] i_measured_angle;
    logic [DT_W-1:0]          i_time_step;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_angle_estimate;
    logic signed [DATA_W-1:0] o_corrected_rate;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [DATA_W-1:0]        i_cfg_data;

    gyro_angle_kalman_filter_top u_dut (.*);

    // Pending samples, expected estimates, and bookkeeping.
    t_sample   sample_q[$];
    t_estimate estimate_q[$];
    int        fail_count = 0;
    int        samples_sent = 0;
    int        estimates_seen = 0;
    int        cfg_writes = 0;
    int        cycle_count = 0;
    bit        quiet_mode = 0;     // no gaps, no stalls
    bit        send_hold = 0;      // sender paused
    int        hold_req = 0;       // long receiver hold-off requests
    int        hold_seen = 0;

    // Predictor copy of the filter registers and state.
    longint q_angle_noise, q_bias_noise, q_meas_noise;
    longint f_angle, f_bias, f_p00, f_p01, f_p10, f_p11;

    // -------------------------------------------------------------------
    // Fixed-point filter arithmetic
    // -------------------------------------------------------------------
    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint signed_capped(logic [127:0] mag, bit neg);
        longint m;
        if (mag > 128'(Q_CAP)) mag = 128'(Q_CAP);
        m = longint'(mag[63:0]);
        return neg ? -m : m;
    endfunction

    // (a*b) >> 24, truncated toward zero
    function automatic longint q24_mul(longint a, longint b);
        logic [127:0] ma, mb;
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        return signed_capped((ma * mb) >> FRAC_CV, (a < 0) != (b < 0));
    endfunction

    // (n << 24) / d for d > 0, truncated toward zero
    function automatic longint q24_div(longint n, longint d);
        logic [127:0] mn;
        mn = 128'(n < 0 ? -n : n);
        return signed_capped((mn << FRAC_CV) / 128'(d), n < 0);
    endfunction

    // One predict/correct pass; returns the estimate the block must report.
    function automatic t_estimate filter_sample(t_sample s);
        t_estimate e;
        longint rate_adj, d11, inner, var_s, k0, k1, innov, o00, o01, dt;
        dt       = longint'(s.dt);
        rate_adj = sat32(longint'(s.rate) - f_bias);
        f_angle  = sat32(f_angle + q24_mul(dt, rate_adj));
        d11      = q24_mul(dt, f_p11);
        inner    = sat32(d11 - f_p01 - f_p10 + q_angle_noise);
        f_p00    = sat32(f_p00 + q24_mul(dt, inner));
        f_p01    = sat32(f_p01 - d11);
        f_p10    = sat32(f_p10 - d11);
        f_p11    = sat32(f_p11 + q24_mul(q_bias_noise, dt));
        var_s    = f_p00 + q_meas_noise;
        if (var_s > 0) begin
            k0 = sat32(q24_div(f_p00, var_s));
            k1 = sat32(q24_div(f_p10, var_s));
        end else begin
            k0 = 0;     // innovation variance not positive: no correction
            k1 = 0;
        end
        innov   = sat32(longint'(s.meas) - f_angle);
        f_angle = sat32(f_angle + q24_mul(k0, innov));
        f_bias  = sat32(f_bias + q24_mul(k1, innov));
        o00 = f_p00;
        o01 = f_p01;
        f_p00 = sat32(f_p00 - q24_mul(k0, o00));
        f_p01 = sat32(f_p01 - q24_mul(k0, o01));
        f_p10 = sat32(f_p10 - q24_mul(k1, o00));
        f_p11 = sat32(f_p11 - q24_mul(k1, o01));
        e.angle = f_angle[31:0];
        e.rate  = rate_adj[31:0];
        return e;
    endfunction

    function automatic void filter_reset();
        q_angle_noise = longint'(ANGLE_NOISE_RST);
        q_bias_noise  = longint'(BIAS_NOISE_RST);
        q_meas_noise  = longint'(MEAS_NOISE_RST);
        f_angle = longint'(START_ANGLE_RST);
        f_bias  = 0;
        f_p00 = 0; f_p01 = 0; f_p10 = 0; f_p11 = 0;
    endfunction

    // Mostly short gaps, some long ones.
    function automatic int idle_len();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 5);
        return $urandom_range(20, 150);
    endfunction

    // Random sample: mostly plausible sensor values, some full-range noise.
    function automatic t_sample rand_sample();
        t_sample s;
        if ($urandom_range(0, 9) < 8) begin
            s.rate = $signed($urandom_range(0, 32'd2621440)) - 32'sd1310720;
            s.meas = $signed($urandom_range(0, 32'd47185920)) - 32'sd23592960;
        end else begin
            s.rate = $urandom;
            s.meas = $urandom;
        end
        s.dt = ($urandom_range(0, 9) < 8) ? 24'($urandom_range(1, 500000)) : 24'($urandom);
        return s;
    endfunction

    // -------------------------------------------------------------------
    // Clock, reset and run limit
    // -------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d estimates still expected", $time, estimate_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // Driver: sample channel, fed from sample_q
    // -------------------------------------------------------------------
    int      send_gap;
    t_sample next_s;
    t_sample cur_s;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid          <= 1'b0;
            i_gyro_rate      <= '0;
            i_measured_angle <= '0;
            i_time_step      <= '0;
            send_gap         <= 0;
        end else begin
            // transaction completes: predict its estimate now
            if (i_valid && !o_stall) begin
                estimate_q.push_back(filter_sample(cur_s));
                samples_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (!send_hold && sample_q.size() > 0) begin
                    next_s            = sample_q.pop_front();
                    cur_s            <= next_s;
                    i_gyro_rate      <= next_s.rate;
                    i_measured_angle <= next_s.meas;
                    i_time_step      <= next_s.dt;
                    i_valid          <= 1'b1;
                    send_gap         <= idle_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // Receiver stall: random gaps, plus long hold-offs on request
    // -------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen  <= hold_req;
            stall_left <= 1500;    // long enough for several samples to pile up
            i_stall    <= 1'b1;
        end else begin
            stall_left <= idle_len();
            i_stall    <= 1'b0;
        end
    end

    // -------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest expectation
    // -------------------------------------------------------------------
    t_estimate want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            estimates_seen++;
            if (estimate_q.size() == 0) begin
                $display("%0t: unexpected result angle=%0d rate=%0d", $time,
                         o_angle_estimate, o_corrected_rate);
                fail_count++;
            end else begin
                want = estimate_q.pop_front();
                if (o_angle_estimate !== want.angle) begin
                    $display("%0t: angle_estimate expected %0d got %0d", $time,
                             want.angle, o_angle_estimate);
                    fail_count++;
                end
                if (o_corrected_rate !== want.rate) begin
                    $display("%0t: corrected_rate expected %0d got %0d", $time,
                             want.rate, o_corrected_rate);
                    fail_count++;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // Sequencer
    // -------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_ANGLE_NOISE: q_angle_noise = longint'(data[30:0]);
            CFG_BIAS_NOISE:  q_bias_noise  = longint'(data[30:0]);
            CFG_MEAS_NOISE:  q_meas_noise  = longint'(data[30:0]);
            CFG_START_ANGLE: f_angle       = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (sample_q.size() > 0 || i_valid || estimate_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_sample(logic [31:0] rate, logic [31:0] meas, logic [23:0] dt);
        t_sample s;
        s.rate = rate;
        s.meas = meas;
        s.dt   = dt;
        sample_q.push_back(s);
    endtask

    task automatic push_random(int n);
        repeat (n) sample_q.push_back(rand_sample());
    endtask

    initial begin
        filter_reset();
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes at reset settings, no idling.
        quiet_mode = 1;
        push_sample(32'h0000_0000, 32'h00B4_0000, 24'd167772);
        push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
        push_sample(32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'd0);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
        push_sample(32'hFFFF_FFFF, 32'h0000_0001, 24'h80_0000);
        push_sample(32'h0001_0000, 32'hFFFF_0000, 24'd167772);
        wait_idle();

        // Innovation variance test: all noise off, start angle cleared.
        cfg_write(CFG_ANGLE_NOISE, 32'h0);
        cfg_write(CFG_BIAS_NOISE, 32'h0);
        cfg_write(CFG_MEAS_NOISE, 32'h0);
        cfg_write(CFG_START_ANGLE, 32'h0000_0000);
        push_sample(32'h0005_0000, 32'h0010_0000, 24'd0);
        push_sample(32'h0005_0000, 32'h0010_0000, 24'd167772);
        wait_idle();
        // zero measure noise with nonzero covariance: gain one
        cfg_write(CFG_ANGLE_NOISE, 32'h0100_0000);
        push_sample(32'h0005_0000, 32'h0010_0000, 24'd167772);
        push_sample(32'hFFF0_0000, 32'hFF00_0000, 24'hFF_FFFF);
        wait_idle();

        // Register extremes, full-width data (top bit of noise data is dropped)
        cfg_write(CFG_ANGLE_NOISE, 32'hFFFF_FFFF);
        cfg_write(CFG_BIAS_NOISE, 32'hFFFF_FFFF);
        cfg_write(CFG_MEAS_NOISE, 32'h8000_0001);
        cfg_write(CFG_START_ANGLE, 32'h7FFF_FFFF);
        cfg_write(CFG_UNUSED, 32'hDEAD_BEEF);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
        push_sample(32'h1234_5678, 32'h8000_0000, 24'd1);
        push_sample(32'h0000_0000, 32'h0000_0000, 24'h7F_FFFF);
        wait_idle();
        cfg_write(CFG_START_ANGLE, 32'h8000_0000);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
        wait_idle();
        quiet_mode = 0;

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_ANGLE_NOISE, 32'(ANGLE_NOISE_RST));
                    cfg_write(CFG_BIAS_NOISE, 32'(BIAS_NOISE_RST));
                    cfg_write(CFG_MEAS_NOISE, 32'(MEAS_NOISE_RST));
                    cfg_write(CFG_START_ANGLE, 32'(START_ANGLE_RST));
                end
                1: begin
                    cfg_write(CFG_MEAS_NOISE, 32'd1);
                    cfg_write(CFG_ANGLE_NOISE, 32'd0);
                end
                default: begin
                    cfg_write(CFG_ANGLE_NOISE, $urandom_range(0, 32'd2000000));
                    cfg_write(CFG_BIAS_NOISE, $urandom_range(0, 32'd2000000));
                    cfg_write(CFG_MEAS_NOISE, ($urandom_range(0, 3) == 0) ? $urandom
                                              : $urandom_range(1, 32'd5000000));
                    cfg_write(CFG_START_ANGLE, $urandom);
                end
            endcase
            quiet_mode = (ph == 4);
            push_random(160);
            if (ph == 2) begin
                // receiver holds off while the sender keeps offering
                hold_req++;
            end
            if (ph == 3) begin
                // sender pauses until every pending estimate has come back
                while (sample_q.size() > 0) @(posedge i_clk);
                send_hold = 1;
                while (i_valid || estimate_q.size() > 0) @(posedge i_clk);
                send_hold = 0;
            end
            push_random(160);
            wait_idle();
        end

        $display("Ran %0d samples, %0d estimates checked, %0d register writes.",
                 samples_sent, estimates_seen, cfg_writes);
        $display("Covered field extremes, zero innovation variance, saturation, stalls.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gakf_pkg.sv
rtl/gakf_mul.sv
rtl/gakf_div.sv
rtl/gakf_dp.sv
rtl/gakf_ctrl.sv
rtl/gyro_angle_kalman_filter_top.sv
tb/gyro_angle_kalman_filter_top_tb.sv
